>>> src/strq_pkg.sv
package strq_pkg;

    // Default table depth
    localparam int STRQ_DEPTH = 32;

    // Field widths
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int WHOLE_W = 16;
    localparam int PLUS_W  = 17;
    localparam int STAT_W  = 2;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 3 * VAL_W;
    localparam int OUT_FLDS_W = POS_W + VAL_W + WHOLE_W + PLUS_W;
    localparam int OUT_DATA_W = ((OUT_FLDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOMATCH = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_END,
        ST_SRCH,
        ST_SRCH_END,
        ST_REPLY
    } strq_state_t;

    // Q16.16 whole part, truncated toward zero
    function automatic logic signed [WHOLE_W-1:0] whole_of(input logic signed [VAL_W-1:0] v);
        logic signed [WHOLE_W-1:0] w;
        w = v[VAL_W-1:VAL_W-WHOLE_W];
        if (v[VAL_W-1] && (v[VAL_W-WHOLE_W-1:0] != '0))
        begin
            w = w + 16'sd1;
        end
        return w;
    endfunction

endpackage

>>> src/strq_ram.sv
module strq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sorted_table_range_query_unit.sv
// Sorted table with insert and inclusive range search, one comparator over a RAM.
// Insert: scans the stored entries, swapping each larger one with the carried value,
// then writes the largest into the new end slot; a full table refuses without a scan.
// Search: scans the stored entries and sends each match, flagging the last, or one no-match
// beat. One item at a time; one RAM read per cycle sets the pace unless a match waits on output.
// Reset: entry count and control clear at once; table contents stay undefined.
module sorted_table_range_query_unit #(
    parameter int DEPTH = strq_pkg::STRQ_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: new_value [31:0], range_low [63:32], range_high [95:64]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [strq_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: operation [0]
    input  logic [0:0]                      s_tuser,
    // m_tdata: position [4:0], found_value [36:5], whole_part [52:37],
    //          whole_plus_one [69:53], zero pad [71:70]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [strq_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: status [1:0]
    output logic [strq_pkg::STAT_W-1:0]     m_tuser,
    output logic                            m_tlast
);

    import strq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    strq_state_t state_reg, state_next;

    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic signed [VAL_W-1:0] carry_reg, carry_next;
    logic signed [VAL_W-1:0] lo_reg, lo_next;
    logic signed [VAL_W-1:0] hi_reg, hi_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [IW-1:0]           pend_idx_reg, pend_idx_next;
    logic signed [VAL_W-1:0] pend_val_reg, pend_val_next;
    logic [STAT_W-1:0]       resp_status_reg, resp_status_next;

    logic                    out_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic [STAT_W-1:0]       out_user_reg;
    logic                    out_last_reg;

    // RAM port signals
    logic                    ram_wr_en;
    logic [IW-1:0]           ram_wr_addr;
    logic [VAL_W-1:0]        ram_wr_data;
    logic                    ram_rd_en;
    logic [VAL_W-1:0]        ram_rd_data;
    logic signed [VAL_W-1:0] rd_val;

    // Result push into the output register
    logic                    push;
    logic [STAT_W-1:0]       push_status;
    logic [IW-1:0]           push_idx;
    logic signed [VAL_W-1:0] push_val;
    logic                    push_has_val;
    logic                    push_last;
    logic signed [WHOLE_W-1:0] push_whole;
    logic signed [PLUS_W-1:0]  push_plus;

    logic in_fire;
    logic out_free;
    logic table_full;
    logic scan_done;
    logic in_range;
    logic stall;

    strq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_val     = $signed(ram_rd_data);
    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign table_full = (count_reg == CW'(DEPTH));
    assign scan_done  = (rd_cnt_reg == count_reg) && !cmp_valid_reg;
    assign in_range   = (rd_val >= lo_reg) && (rd_val <= hi_reg);

    // A new match must first push out the held one
    assign stall = (state_reg == ST_SRCH) && cmp_valid_reg && in_range &&
                   pend_valid_reg && !out_free;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser[0] == OP_SEARCH)
                        state_next = ST_SRCH;
                    else if (table_full)
                        state_next = ST_REPLY;
                    else
                        state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                if (scan_done)
                    state_next = ST_INS_END;
            end
            ST_INS_END:
            begin
                state_next = ST_REPLY;
            end
            ST_SRCH:
            begin
                if (scan_done)
                    state_next = ST_SRCH_END;
            end
            ST_SRCH_END, ST_REPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and sequencer outputs
    always_comb
    begin
        count_next       = count_reg;
        rd_cnt_next      = rd_cnt_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        carry_next       = carry_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        pend_valid_next  = pend_valid_reg;
        pend_idx_next    = pend_idx_reg;
        pend_val_next    = pend_val_reg;
        resp_status_next = resp_status_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = cmp_idx_reg;
        ram_wr_data      = carry_reg;
        ram_rd_en        = 1'b0;
        push             = 1'b0;
        push_status      = STATUS_OK;
        push_idx         = pend_idx_reg;
        push_val         = pend_val_reg;
        push_has_val     = 1'b0;
        push_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rd_cnt_next     = '0;
                    cmp_valid_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    carry_next      = $signed(s_tdata[VAL_W-1:0]);
                    lo_next         = $signed(s_tdata[2*VAL_W-1:VAL_W]);
                    hi_next         = $signed(s_tdata[3*VAL_W-1:2*VAL_W]);
                    resp_status_next = table_full ? STATUS_FULL : STATUS_OK;
                end
            end
            ST_INS, ST_SRCH:
            begin
                if (!stall)
                begin
                    // issue the next table read
                    if (rd_cnt_reg < count_reg)
                    begin
                        ram_rd_en      = 1'b1;
                        rd_cnt_next    = rd_cnt_reg + 1'b1;
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = rd_cnt_reg[IW-1:0];
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                    end
                    // compare the entry from the previous read
                    if (cmp_valid_reg)
                    begin
                        if (state_reg == ST_INS)
                        begin
                            // larger entry swaps with the carried value
                            if (rd_val > carry_reg)
                            begin
                                ram_wr_en  = 1'b1;
                                carry_next = rd_val;
                            end
                        end
                        else if (in_range)
                        begin
                            if (pend_valid_reg)
                            begin
                                push         = 1'b1;
                                push_has_val = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            pend_idx_next   = cmp_idx_reg;
                            pend_val_next   = rd_val;
                        end
                    end
                end
            end
            ST_INS_END:
            begin
                // largest value lands in the new end slot
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_reg[IW-1:0];
                count_next  = count_reg + 1'b1;
            end
            ST_SRCH_END:
            begin
                if (out_free)
                begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    push_has_val = pend_valid_reg;
                    push_status  = pend_valid_reg ? STATUS_OK : STATUS_NOMATCH;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    push_last   = 1'b1;
                    push_status = resp_status_reg;
                end
            end
            default:
            begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    assign push_whole = whole_of(push_val);
    assign push_plus  = PLUS_W'(push_whole) + 17'sd1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_cnt_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        carry_reg       <= carry_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        pend_idx_reg    <= pend_idx_next;
        pend_val_reg    <= pend_val_next;
        resp_status_reg <= resp_status_next;
        if (push)
        begin
            out_user_reg <= push_status;
            out_last_reg <= push_last;
            if (push_has_val)
                out_data_reg <= OUT_DATA_W'({push_plus, push_whole, push_val,
                                             POS_W'(push_idx)});
            else
                out_data_reg <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> verif/sorted_table_range_query_unit_tb.sv
`timescale 1ns / 100ps

module sorted_table_range_query_unit_tb;

    import strq_pkg::*;

    localparam int DEPTH       = STRQ_DEPTH;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = DEPTH + 16;

    // m_tdata field offsets, lowest first
    localparam int POS_LO   = 0;
    localparam int VAL_LO   = POS_LO + POS_W;
    localparam int WHOLE_LO = VAL_LO + VAL_W;
    localparam int PLUS_LO  = WHOLE_LO + WHOLE_W;

    typedef struct {
        logic                    op;
        logic signed [VAL_W-1:0] new_value;
        logic signed [VAL_W-1:0] range_low;
        logic signed [VAL_W-1:0] range_high;
    } query_t;

    typedef struct {
        logic [STAT_W-1:0]         status;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   found_value;
        logic signed [WHOLE_W-1:0] whole_part;
        logic signed [PLUS_W-1:0]  whole_plus_one;
        logic                      last;
    } reply_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  m_tlast;

    // stimulus and scoreboard
    query_t query_q[$];
    reply_t reply_q[$];
    query_t cur_query;
    logic signed [VAL_W-1:0] gen_vals[$];
    int gen_inserts = 0;

    // shadow copy of the sorted table
    logic signed [VAL_W-1:0] shadow_table[DEPTH];
    int shadow_count = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_done      = 0;
    int hold_left      = 0;

    int errors    = 0;
    int n_inserts = 0;
    int n_search  = 0;
    int n_full    = 0;
    int n_nomatch = 0;
    int n_beats   = 0;
    int max_hits  = 0;

    sorted_table_range_query_unit #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Builds one result beat; value-less beats carry zeros
    function automatic reply_t make_reply(logic [STAT_W-1:0] st, int pos,
                                          logic signed [VAL_W-1:0] v, logic has_val);
        reply_t r;
        int     w;
        r        = '{default: '0};
        r.status = st;
        if (has_val)
        begin
            w                = v / 65536;
            r.position       = pos[POS_W-1:0];
            r.found_value    = v;
            r.whole_part     = w[WHOLE_W-1:0];
            r.whole_plus_one = PLUS_W'(w + 1);
        end
        return r;
    endfunction

    // Applies one accepted query to the shadow table and queues its results
    task automatic predict_replies(input query_t q);
        reply_t                  r;
        logic signed [VAL_W-1:0] t;
        int                      i;
        int                      hits;
        hits = 0;
        if (q.op == OP_INSERT)
        begin
            n_inserts++;
            if (shadow_count >= DEPTH)
            begin
                r = make_reply(STATUS_FULL, 0, '0, 1'b0);
                n_full++;
            end
            else
            begin
                // append, then swap larger entries into the end slot
                shadow_table[shadow_count] = q.new_value;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_table[i] > shadow_table[shadow_count])
                    begin
                        t                          = shadow_table[i];
                        shadow_table[i]            = shadow_table[shadow_count];
                        shadow_table[shadow_count] = t;
                    end
                end
                shadow_count++;
                r = make_reply(STATUS_OK, 0, '0, 1'b0);
            end
            r.last = 1'b1;
            reply_q.push_back(r);
        end
        else
        begin
            n_search++;
            for (i = 0; i < shadow_count; i++)
            begin
                if (shadow_table[i] >= q.range_low && shadow_table[i] <= q.range_high)
                begin
                    r      = make_reply(STATUS_OK, i, shadow_table[i], 1'b1);
                    r.last = 1'b0;
                    reply_q.push_back(r);
                    hits++;
                end
            end
            if (hits == 0)
            begin
                r      = make_reply(STATUS_NOMATCH, 0, '0, 1'b0);
                r.last = 1'b1;
                reply_q.push_back(r);
                n_nomatch++;
            end
            else
            begin
                reply_q[reply_q.size() - 1].last = 1'b1;
            end
            if (hits > max_hits)
                max_hits = hits;
        end
    endtask

    // Driver: offers the next pending query, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                predict_replies(cur_query);
            if (query_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_query = query_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_query.range_high, cur_query.range_low, cur_query.new_value};
                s_tuser  <= cur_query.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_done != hold_asked)
            begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: compares each result beat with the oldest expectation
    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_beats++;
            got.status         = m_tuser;
            got.position       = m_tdata[POS_LO +: POS_W];
            got.found_value    = m_tdata[VAL_LO +: VAL_W];
            got.whole_part     = m_tdata[WHOLE_LO +: WHOLE_W];
            got.whole_plus_one = m_tdata[PLUS_LO +: PLUS_W];
            got.last           = m_tlast;
            if (reply_q.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d position %0d",
                       got.status, got.position);
                errors++;
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("position", want.position, got.position);
                check_field("found_value", want.found_value, got.found_value);
                check_field("whole_part", want.whole_part, got.whole_part);
                check_field("whole_plus_one", want.whole_plus_one, got.whole_plus_one);
                check_field("last", want.last, got.last);
            end
        end
    end

    task automatic push_insert(input logic signed [VAL_W-1:0] v);
        query_t q;
        q.op         = OP_INSERT;
        q.new_value  = v;
        q.range_low  = $urandom;
        q.range_high = $urandom;
        query_q.push_back(q);
        if (gen_vals.size() < DEPTH)
            gen_vals.push_back(v);
        gen_inserts++;
    endtask

    task automatic push_search(input logic signed [VAL_W-1:0] lo,
                               input logic signed [VAL_W-1:0] hi);
        query_t q;
        q.op         = OP_SEARCH;
        q.new_value  = $urandom;
        q.range_low  = lo;
        q.range_high = hi;
        query_q.push_back(q);
    endtask

    // Q16.16 values biased towards fractions near zero, whole numbers,
    // extremes and repeats of earlier inserts
    function automatic logic signed [VAL_W-1:0] rand_q16();
        case ($urandom_range(5))
            1: return $signed($urandom_range(0, 262143)) - 131072;
            2: return ($signed($urandom_range(0, 400)) - 200) * 65536;
            3:
            begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'shFFFF_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            4:
            begin
                if (gen_vals.size() != 0)
                    return gen_vals[$urandom_range(gen_vals.size() - 1)];
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] near_stored();
        logic signed [VAL_W-1:0] v;
        if (gen_vals.size() == 0)
            return rand_q16();
        v = gen_vals[$urandom_range(gen_vals.size() - 1)];
        case ($urandom_range(3))
            0: return v - 1;
            1: return v + 1;
            default: return v;
        endcase
    endfunction

    // Mix of inserts and searches; search bounds mostly around stored values, the rest random or reversed
    task automatic gen_items(input int n);
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] t;
        int                      k;
        repeat (n)
        begin
            if ($urandom_range(99) < ((gen_inserts < DEPTH + 4) ? 55 : 20))
            begin
                push_insert(rand_q16());
            end
            else
            begin
                k = $urandom_range(99);
                if (k < 70)
                begin
                    lo = near_stored();
                    hi = near_stored();
                    if (lo > hi)
                    begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                else if (k < 85)
                begin
                    lo = $urandom;
                    hi = $urandom;
                end
                else
                begin
                    lo = rand_q16();
                    hi = rand_q16();
                    if (lo <= hi)
                    begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                push_search(lo, hi);
            end
        end
    endtask

    task automatic wait_sent();
        while (query_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        while (query_q.size() != 0 || s_tvalid || reply_q.size() != 0)
            @(negedge clk);
    endtask

    // Run limit
    initial
    begin
        #(64'd8_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, second entry smaller, duplicates
        push_search(32'sh8000_0000, 32'sh7FFF_FFFF);
        push_insert(32'sh0001_8000);
        push_insert(32'shFFFE_8000);
        push_insert(32'sh8000_0000);
        push_insert(32'sh7FFF_FFFF);
        push_insert(32'sh0001_8000);
        push_insert(32'shFFFF_FFFF);
        push_insert(32'shFFFF_0000);
        push_insert(32'sh0000_0000);
        push_search(32'sh8000_0000, 32'sh7FFF_FFFF);
        push_search(32'sh0000_0005, 32'shFFFF_FFFB);
        push_search(32'sh0001_8000, 32'sh0001_8000);
        push_search(32'sh8000_0000, 32'sh8000_0000);
        push_search(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_search(32'sh0002_0000, 32'sh0003_0000);
        push_search(32'shFFFF_0000, 32'shFFFF_FFFF);
        wait_drained();

        // no idling; fills the table
        gen_items(100);
        wait_sent();

        // long receiver hold while queries keep coming, then drain fully
        hold_asked++;
        gen_items(12);
        wait_drained();

        send_idle_pct  = 86;
        recv_stall_pct = 0;
        gen_items(100);
        wait_sent();

        send_idle_pct  = 0;
        recv_stall_pct = 86;
        gen_items(100);
        wait_sent();

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        gen_items(100);
        wait_drained();

        repeat (SETTLE) @(negedge clk);
        if (reply_q.size() != 0)
        begin
            $error("%0d expected results never arrived", reply_q.size());
            errors++;
        end

        $display("Covered %0d inserts (%0d refused as full) and %0d searches (%0d without match)",
                 n_inserts, n_full, n_search, n_nomatch);
        $display("Checked %0d result beats, up to %0d matches per search, %0d errors",
                 n_beats, max_hits, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
